/* rtl/dda_pkg.sv */
// ----------------------------------------------------------------------------
// dda_pkg: shared types and constants of the DDA line rasterizer
// Default widths, the input action codes and the divider status word.
// ----------------------------------------------------------------------------
package dda_pkg;

  localparam int unsigned COORD_BITS_DEF = 13;
  localparam int unsigned FRAC_BITS_DEF  = 16;
  localparam int unsigned COLOR_BITS     = 24;
  localparam logic [COLOR_BITS-1:0] COLOR_RESET = 24'hFFFFFF;

  // kind of an input item, carried in tuser
  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_STEP = 1'b1
  } action_e;

  // status of one divider lane
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

/* rtl/dda_div.sv */
// ----------------------------------------------------------------------------
// dda_div: bit-serial restoring divider, one quotient bit per cycle
// Gives (num * 2^FRAC_BITS) / den truncated toward zero, for |num| <= den.
// ----------------------------------------------------------------------------
module dda_div #(
  parameter int unsigned MAG_BITS  = 13,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic signed [MAG_BITS:0]    num_i,
  input  logic        [MAG_BITS-1:0]  den_i,
  output logic signed [FRAC_BITS+1:0] quo_o,
  output dda_pkg::div_stat_t          stat_o
);
  import dda_pkg::*;

  localparam int unsigned CNT_W = $clog2(FRAC_BITS + 1);

  logic [MAG_BITS-1:0]  rem_q, rem_d;
  logic [MAG_BITS-1:0]  den_q;
  logic [FRAC_BITS:0]   quo_q, quo_d;
  logic                 neg_q;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic                 busy_q, busy_d;
  logic                 done_q, done_d;

  logic [MAG_BITS:0]    num_abs;
  logic [MAG_BITS:0]    trial;
  logic [MAG_BITS:0]    trial_sub;
  logic                 ge;
  logic [FRAC_BITS+1:0] quo_mag;

  assign num_abs = num_i[MAG_BITS] ? (MAG_BITS+1)'(-num_i) : num_i;

  // first step is the integer bit, later steps shift the remainder
  assign trial     = (cnt_q == '0) ? {1'b0, rem_q} : {rem_q, 1'b0};
  assign trial_sub = trial - {1'b0, den_q};
  assign ge        = (trial >= {1'b0, den_q});

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = num_abs[MAG_BITS-1:0];
      quo_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? trial_sub[MAG_BITS-1:0] : trial[MAG_BITS-1:0];
      quo_d = {quo_q[FRAC_BITS-1:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(FRAC_BITS)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      den_q <= den_i;
      neg_q <= num_i[MAG_BITS];
    end
  end

  assign quo_mag = {1'b0, quo_q};
  assign quo_o   = neg_q ? (FRAC_BITS+2)'(-quo_mag) : quo_mag;

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

/* rtl/dda_axis.sv */
// ----------------------------------------------------------------------------
// dda_axis: position accumulator of one axis
// Keeps position and distance to target in fixed point, advances both.
// ----------------------------------------------------------------------------
module dda_axis #(
  parameter int unsigned COORD_BITS = 13,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                         clk_i,
  input  logic                         load_i,
  input  logic signed [COORD_BITS-1:0] start_i,
  input  logic signed [COORD_BITS-1:0] end_i,
  input  logic                         inc_we_i,
  input  logic signed [FRAC_BITS+1:0]  inc_i,
  input  logic                         adv_i,
  output logic signed [COORD_BITS-1:0] pix_o,
  output logic                         near_o
);
  import dda_pkg::*;

  localparam int unsigned POS_W  = COORD_BITS + FRAC_BITS;
  localparam int unsigned DIFF_W = COORD_BITS + FRAC_BITS + 1;
  localparam int unsigned INC_W  = FRAC_BITS + 2;

  logic signed [POS_W-1:0]  pos_q;
  logic signed [DIFF_W-1:0] diff_q;
  logic signed [INC_W-1:0]  inc_q;

  logic signed [COORD_BITS:0] d0;
  logic [POS_W-1:0]           inc_pos;
  logic [DIFF_W-1:0]          inc_diff;
  logic [DIFF_W-1:0]          diff_nx;
  logic [COORD_BITS:0]        diff_int;

  assign d0       = {start_i[COORD_BITS-1], start_i} - {end_i[COORD_BITS-1], end_i};
  assign inc_pos  = {{(POS_W-INC_W){inc_q[INC_W-1]}}, inc_q};
  assign inc_diff = {{(DIFF_W-INC_W){inc_q[INC_W-1]}}, inc_q};

  // distance after the coming advance; within one unit ends the line
  assign diff_nx  = diff_q + inc_diff;
  assign diff_int = diff_nx[DIFF_W-1:FRAC_BITS];
  assign near_o   = (diff_int == '0) ||
                    ((diff_int == '1) && (diff_nx[FRAC_BITS-1:0] != '0));

  // truncation toward zero
  assign pix_o = pos_q[POS_W-1:FRAC_BITS] +
                 COORD_BITS'(pos_q[POS_W-1] && (pos_q[FRAC_BITS-1:0] != '0));

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      pos_q  <= {start_i, {FRAC_BITS{1'b0}}};
      diff_q <= {d0, {FRAC_BITS{1'b0}}};
    end else if (adv_i) begin
      pos_q  <= pos_q + inc_pos;
      diff_q <= diff_nx;
    end
    if (inc_we_i) begin
      inc_q <= inc_i;
    end
  end

endmodule

/* rtl/dda_line_rasterizer.sv */
// ----------------------------------------------------------------------------
// dda_line_rasterizer: DDA line rasterizer with fixed-point increments
// Loads a line, then emits one pixel per step item until the end point.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries items. tuser = 0 loads a line from the end points in
//   tdata; tuser = 1 asks for the next pixel. A load gives no output item;
//   a step with no line in progress is swallowed silently.
//   m_axis carries pixels: x, y, colour, and tlast on the line's final pixel.
//   The end point itself is never drawn; a zero-length line draws nothing.
//   cfg_* writes the draw colour; always ready, takes effect on the next step.
// Timing:
//   A load of a non-zero line holds s_axis_tready low while the two
//   bit-serial dividers, one bit per cycle each, find their FRAC_BITS + 1
//   quotient bits; the increments are then written back and tready rises
//   again. A zero-length load does not start the dividers.
//   Step items are taken one per cycle while the output is not stalled;
//   each pixel goes to the output register when its step item is accepted.
// Reset: no line in progress, colour white, output empty.
// Stall: a single output register; while it is full and m_axis_tready is low,
//   s_axis_tready is low and nothing is lost.
// ----------------------------------------------------------------------------
module dda_line_rasterizer #(
  parameter int unsigned COORD_BITS = dda_pkg::COORD_BITS_DEF,
  parameter int unsigned FRAC_BITS  = dda_pkg::FRAC_BITS_DEF,
  localparam int unsigned IN_W  = ((4 * COORD_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_W = ((2 * COORD_BITS + dda_pkg::COLOR_BITS + 7) / 8) * 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // tdata: x_start, y_start, x_end, y_end, zero pad
  input  logic [IN_W-1:0]                s_axis_tdata,
  // tuser: action (0 load, 1 step)
  input  logic [0:0]                     s_axis_tuser,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // tdata: pixel_x, pixel_y, pixel_color, zero pad
  output logic [OUT_W-1:0]               m_axis_tdata,
  output logic                           m_axis_tlast,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic [dda_pkg::COLOR_BITS-1:0] cfg_data_i,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o
);
  import dda_pkg::*;

  typedef enum logic [1:0] {
    ST_RUN = 2'b01,
    ST_DIV = 2'b10
  } state_e;

  state_e                  state_q, state_d;
  logic                    line_active_q, line_active_d;
  logic [COORD_BITS-1:0]   steps_left_q, steps_left_d;
  logic [COLOR_BITS-1:0]   draw_color_q;
  logic                    m_valid_q, m_valid_d;
  logic [OUT_W-1:0]        m_data_q;
  logic                    m_last_q;

  logic signed [COORD_BITS-1:0] xs, ys, xe, ye;
  logic signed [COORD_BITS:0]   dx, dy;
  logic [COORD_BITS:0]          adx, ady;
  logic [COORD_BITS-1:0]        n_len;
  action_e                      action;

  logic in_fire, load_fire, step_fire, div_start, last_pix;

  logic signed [FRAC_BITS+1:0]  inc_x, inc_y;
  div_stat_t                    stat_x, stat_y;
  logic signed [COORD_BITS-1:0] pix_x, pix_y;
  logic                         near_x, near_y;

  // unpack the load item
  assign xs = s_axis_tdata[COORD_BITS-1:0];
  assign ys = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
  assign xe = s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS];
  assign ye = s_axis_tdata[4*COORD_BITS-1:3*COORD_BITS];
  assign action = action_e'(s_axis_tuser[0]);

  assign dx  = {xe[COORD_BITS-1], xe} - {xs[COORD_BITS-1], xs};
  assign dy  = {ye[COORD_BITS-1], ye} - {ys[COORD_BITS-1], ys};
  assign adx = dx[COORD_BITS] ? (COORD_BITS+1)'(-dx) : dx;
  assign ady = dy[COORD_BITS] ? (COORD_BITS+1)'(-dy) : dy;
  // major-axis length; the coordinate range keeps it within COORD_BITS
  assign n_len = (adx > ady) ? adx[COORD_BITS-1:0] : ady[COORD_BITS-1:0];

  // handshakes
  assign s_axis_tready = (state_q == ST_RUN) && (!m_valid_q || m_axis_tready);
  assign in_fire   = s_axis_tvalid && s_axis_tready;
  assign load_fire = in_fire && (action == ACT_LOAD);
  assign step_fire = in_fire && (action == ACT_STEP) && line_active_q;
  assign div_start = load_fire && (n_len != '0);

  // pixel count guard, or both distances under one unit after the advance
  assign last_pix = (steps_left_q == COORD_BITS'(1)) || (near_x && near_y);

  assign cfg_ready_o = 1'b1;

  dda_div #(
    .MAG_BITS (COORD_BITS),
    .FRAC_BITS(FRAC_BITS)
  ) u_div_x (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (dx),
    .den_i  (n_len),
    .quo_o  (inc_x),
    .stat_o (stat_x)
  );

  dda_div #(
    .MAG_BITS (COORD_BITS),
    .FRAC_BITS(FRAC_BITS)
  ) u_div_y (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (dy),
    .den_i  (n_len),
    .quo_o  (inc_y),
    .stat_o (stat_y)
  );

  dda_axis #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_axis_x (
    .clk_i   (clk_i),
    .load_i  (load_fire),
    .start_i (xs),
    .end_i   (xe),
    .inc_we_i(stat_x.done),
    .inc_i   (inc_x),
    .adv_i   (step_fire),
    .pix_o   (pix_x),
    .near_o  (near_x)
  );

  dda_axis #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_axis_y (
    .clk_i   (clk_i),
    .load_i  (load_fire),
    .start_i (ys),
    .end_i   (ye),
    .inc_we_i(stat_y.done),
    .inc_i   (inc_y),
    .adv_i   (step_fire),
    .pix_o   (pix_y),
    .near_o  (near_y)
  );

  // sequencer: run / dividing
  always_comb begin
    state_d       = state_q;
    line_active_d = line_active_q;
    steps_left_d  = steps_left_q;
    unique case (state_q)
      ST_RUN: begin
        if (load_fire) begin
          line_active_d = 1'b0;
          steps_left_d  = n_len;
          if (div_start) begin
            state_d = ST_DIV;
          end
        end else if (step_fire) begin
          steps_left_d  = steps_left_q - 1'b1;
          line_active_d = !last_pix;
        end
      end
      ST_DIV: begin
        if (stat_x.done) begin
          line_active_d = 1'b1;
          state_d       = ST_RUN;
        end
      end
      default: begin
        state_d = ST_RUN;
      end
    endcase
  end

  // output register
  always_comb begin
    m_valid_d = m_valid_q;
    if (step_fire) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_RUN;
      line_active_q <= 1'b0;
      steps_left_q  <= '0;
      draw_color_q  <= COLOR_RESET;
      m_valid_q     <= 1'b0;
    end else begin
      state_q       <= state_d;
      line_active_q <= line_active_d;
      steps_left_q  <= steps_left_d;
      m_valid_q     <= m_valid_d;
      if (cfg_valid_i) begin
        draw_color_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_fire) begin
      m_data_q <= OUT_W'({draw_color_q, pix_y, pix_x});
      m_last_q <= last_pix;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;

  // ---------------------------------------------------------------- checks
  a_lanes_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stat_x == stat_y))
    else $error("divider lanes out of step");

  a_active_has_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_active_q |-> (steps_left_q != '0))
    else $error("line active with no pixels left");

  a_last_ends_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_fire && last_pix) |=> !line_active_q)
    else $error("line still active after its last pixel");

  // the divider is busy, or has just finished and the increments go in
  a_div_idle_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (!line_active_q && (stat_x.busy || stat_x.done)))
    else $error("dividing state without a busy divider");

endmodule
